// ===== rtl/triangle_point_barycentric_macros.svh =====
// assertion macros shared by the triangle point barycentric rtl
// expects clk and rst_n in the scope of each use
`ifndef TRIANGLE_POINT_BARYCENTRIC_MACROS_SVH
`define TRIANGLE_POINT_BARYCENTRIC_MACROS_SVH

// same-cycle implication
`define TPB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpb check failed");

// next-cycle implication
`define TPB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpb check failed");

// condition that must never hold
`define TPB_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tpb check failed");

`endif

// ===== rtl/tpb_pkg.sv =====
// shared types and fixed widths of the triangle point barycentric block
// no dependencies
package tpb_pkg;

    localparam int CoordW     = 32;
    localparam int DiffW      = 33;
    localparam int ProdW      = 66;
    localparam int DotW       = 68;
    localparam int HalfW      = 34;
    localparam int BigW       = 136;
    localparam int NumW       = 137;
    localparam int QBits      = 32;
    localparam int QueueDepth = 4;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    // exact determinant and numerators handed from front to back
    typedef struct packed {
        logic [NumW-1:0]        den;
        logic signed [NumW-1:0] num1;
        logic signed [NumW-1:0] num2;
        logic                   degen;
    } geom_t;

endpackage

// ===== rtl/tpb_front.sv =====
// front end: edge vectors, dot products and exact cramer terms
// depends on tpb_pkg
module tpb_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tpb_pkg::vec3_t node0,
    input  tpb_pkg::vec3_t node1,
    input  tpb_pkg::vec3_t node2,
    input  tpb_pkg::vec3_t query,
    output logic          out_valid,
    input  logic          out_ready,
    output tpb_pkg::geom_t out_geom
);

    localparam int NStg = 6;

    logic                                 v_reg [NStg];
    logic                                 rdy   [NStg+1];

    logic signed [tpb_pkg::DiffW-1:0]     c1_next [3], c2_next [3], d_next [3];
    logic signed [tpb_pkg::DiffW-1:0]     c1_reg  [3], c2_reg  [3], d_reg  [3];
    logic signed [tpb_pkg::ProdW-1:0]     pp_next [15], pp_reg [15];
    logic signed [tpb_pkg::DotW-1:0]      dot_next [5], dot_reg [5];
    logic signed [tpb_pkg::DotW-1:0]      opa [6], opb [6];
    logic signed [tpb_pkg::HalfW-1:0]     ah [6], bh [6];
    logic [tpb_pkg::HalfW-1:0]            al [6], bl [6];
    logic signed [2*tpb_pkg::HalfW-1:0]   hh_next [6], hh_reg [6];
    logic signed [2*tpb_pkg::HalfW:0]     hl_next [6], hl_reg [6];
    logic signed [2*tpb_pkg::HalfW:0]     lh_next [6], lh_reg [6];
    logic [2*tpb_pkg::HalfW-1:0]          ll_next [6], ll_reg [6];
    logic signed [tpb_pkg::BigW-1:0]      prod_next [6], prod_reg [6];
    tpb_pkg::geom_t                       geom_next, geom_reg;

    logic signed [tpb_pkg::CoordW-1:0]    p0 [3], p1 [3], p2 [3], pq [3];

    // per-stage ready chain
    always_comb
    begin
        rdy[NStg] = out_ready;
        for (int i = NStg - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NStg-1];
    assign out_geom  = geom_reg;

    // stage one: edge and query differences
    always_comb
    begin
        p0[0] = node0.x; p0[1] = node0.y; p0[2] = node0.z;
        p1[0] = node1.x; p1[1] = node1.y; p1[2] = node1.z;
        p2[0] = node2.x; p2[1] = node2.y; p2[2] = node2.z;
        pq[0] = query.x; pq[1] = query.y; pq[2] = query.z;
        for (int k = 0; k < 3; k++)
        begin
            c1_next[k] = {p1[k][31], p1[k]} - {p0[k][31], p0[k]};
            c2_next[k] = {p2[k][31], p2[k]} - {p0[k][31], p0[k]};
            d_next[k]  = {pq[k][31], pq[k]} - {p0[k][31], p0[k]};
        end
    end

    // stage two: component products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pp_next[k]      = c1_reg[k] * c1_reg[k];
            pp_next[3 + k]  = c2_reg[k] * c2_reg[k];
            pp_next[6 + k]  = c1_reg[k] * c2_reg[k];
            pp_next[9 + k]  = d_reg[k] * c1_reg[k];
            pp_next[12 + k] = d_reg[k] * c2_reg[k];
        end
    end

    // stage three: dot products aa bb ab da db
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            dot_next[i] = {{2{pp_reg[3*i][65]}}, pp_reg[3*i]}
                        + {{2{pp_reg[3*i+1][65]}}, pp_reg[3*i+1]}
                        + {{2{pp_reg[3*i+2][65]}}, pp_reg[3*i+2]};
        end
    end

    // stage four: partial products of the six wide products
    always_comb
    begin
        opa[0] = dot_reg[3]; opb[0] = dot_reg[1];
        opa[1] = dot_reg[4]; opb[1] = dot_reg[2];
        opa[2] = dot_reg[0]; opb[2] = dot_reg[4];
        opa[3] = dot_reg[2]; opb[3] = dot_reg[3];
        opa[4] = dot_reg[0]; opb[4] = dot_reg[1];
        opa[5] = dot_reg[2]; opb[5] = dot_reg[2];
        for (int j = 0; j < 6; j++)
        begin
            ah[j] = opa[j][67:34];
            al[j] = opa[j][33:0];
            bh[j] = opb[j][67:34];
            bl[j] = opb[j][33:0];
            hh_next[j] = ah[j] * bh[j];
            hl_next[j] = ah[j] * $signed({1'b0, bl[j]});
            lh_next[j] = bh[j] * $signed({1'b0, al[j]});
            ll_next[j] = al[j] * bl[j];
        end
    end

    // stage five: recombine partials
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            prod_next[j] = $signed({hh_reg[j], 68'b0})
                         + $signed({{33{hl_reg[j][68]}}, hl_reg[j], 34'b0})
                         + $signed({{33{lh_reg[j][68]}}, lh_reg[j], 34'b0})
                         + $signed({68'b0, ll_reg[j]});
        end
    end

    // stage six: cramer numerators and determinant
    always_comb
    begin
        geom_next.num1 = {prod_reg[0][135], prod_reg[0]} - {prod_reg[1][135], prod_reg[1]};
        geom_next.num2 = {prod_reg[2][135], prod_reg[2]} - {prod_reg[3][135], prod_reg[3]};
        geom_next.den  = {prod_reg[4][135], prod_reg[4]} - {prod_reg[5][135], prod_reg[5]};
        geom_next.degen = (geom_next.den == '0);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NStg; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < NStg; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            c1_reg <= c1_next; c2_reg <= c2_next; d_reg <= d_next;
        end
        if (rdy[1])
        begin
            pp_reg <= pp_next;
        end
        if (rdy[2])
        begin
            dot_reg <= dot_next;
        end
        if (rdy[3])
        begin
            hh_reg <= hh_next; hl_reg <= hl_next; lh_reg <= lh_next; ll_reg <= ll_next;
        end
        if (rdy[4])
        begin
            prod_reg <= prod_next;
        end
        if (rdy[5])
        begin
            geom_reg <= geom_next;
        end
    end

endmodule

// ===== rtl/tpb_queue.sv =====
// short queue between the front and back ends
// depends on tpb_pkg and the assertion macro header
`include "triangle_point_barycentric_macros.svh"

module tpb_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tpb_pkg::geom_t in_geom,
    output logic           out_valid,
    input  logic           out_ready,
    output tpb_pkg::geom_t out_geom
);

    localparam int PtrW = $clog2(tpb_pkg::QueueDepth);

    tpb_pkg::geom_t  store [tpb_pkg::QueueDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0]   count_reg;
    logic            push, pop;

    assign in_ready  = (count_reg != PtrW'(0) + (PtrW+1)'(tpb_pkg::QueueDepth));
    assign out_valid = (count_reg != '0);
    assign out_geom  = store[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // beat storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_reg] <= in_geom;
        end
    end

    `TPB_ASSERT_NEVER(a_q_over, count_reg > (PtrW+1)'(tpb_pkg::QueueDepth))
    `TPB_ASSERT_NEXT(a_q_fill, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== rtl/tpb_back.sv =====
// back end: pipelined restoring division, rounding and saturation
// depends on tpb_pkg
module tpb_back #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpb_pkg::geom_t      in_geom,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  weight_node1,
    output logic signed [31:0]  weight_node2,
    output logic signed [31:0]  weight_node0,
    output logic                inside_res,
    output logic                degenerate
);

    localparam int RemW = tpb_pkg::NumW + FRAC_BITS + 34;
    localparam int NDiv = tpb_pkg::QBits;
    localparam int NStg = NDiv + 2;

    logic                    v_reg [NStg];
    logic                    rdy   [NStg+1];

    logic [RemW-1:0]         r1_reg [NDiv+1], r2_reg [NDiv+1], dv_reg [NDiv+1];
    logic [RemW-1:0]         r1_next [NDiv+1], r2_next [NDiv+1], dv_next;
    logic [NDiv-1:0]         q1_reg [NDiv+1], q2_reg [NDiv+1];
    logic [NDiv-1:0]         q1_next [NDiv+1], q2_next [NDiv+1];
    logic                    s1_reg [NDiv+1], s2_reg [NDiv+1];
    logic                    n1_reg [NDiv+1], n2_reg [NDiv+1], dg_reg [NDiv+1];
    logic                    s1_next, s2_next;
    logic [tpb_pkg::NumW-1:0] abs1, abs2;
    logic [RemW-1:0]         trial;

    logic signed [31:0]      w1, w2, w0;
    logic signed [33:0]      w0_wide, one_wide;
    logic                    ins;
    logic signed [31:0]      w1_reg, w2_reg, w0_reg;
    logic                    ins_reg, dg_out_reg;

    function automatic logic signed [31:0] finish(logic [31:0] q, logic sat, logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            r = (sat || q[31]) ? 32'sh8000_0000 : -$signed(q);
        end
        else
        begin
            r = (sat || q[31]) ? 32'sh7fff_ffff : $signed(q);
        end
        return r;
    endfunction

    // ready chain over all stages
    always_comb
    begin
        rdy[NStg] = out_ready;
        for (int i = NStg - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NStg-1];

    // prep: magnitudes, rounding offset and overflow check
    // then one quotient bit per stage, msb first
    always_comb
    begin
        abs1 = in_geom.num1[tpb_pkg::NumW-1] ? -in_geom.num1 : in_geom.num1;
        abs2 = in_geom.num2[tpb_pkg::NumW-1] ? -in_geom.num2 : in_geom.num2;
        r1_next[0] = (RemW'(abs1) << (FRAC_BITS + 1)) + RemW'(in_geom.den);
        r2_next[0] = (RemW'(abs2) << (FRAC_BITS + 1)) + RemW'(in_geom.den);
        dv_next    = RemW'(in_geom.den) << 1;
        s1_next    = r1_next[0] >= (dv_next << NDiv);
        s2_next    = r2_next[0] >= (dv_next << NDiv);
        q1_next[0] = '0;
        q2_next[0] = '0;
        trial = '0;
        for (int s = 1; s <= NDiv; s++)
        begin
            trial      = dv_reg[s-1] << (NDiv - s);
            r1_next[s] = r1_reg[s-1];
            r2_next[s] = r2_reg[s-1];
            q1_next[s] = q1_reg[s-1];
            q2_next[s] = q2_reg[s-1];
            if (r1_reg[s-1] >= trial)
            begin
                r1_next[s] = r1_reg[s-1] - trial;
                q1_next[s][NDiv - s] = 1'b1;
            end
            if (r2_reg[s-1] >= trial)
            begin
                r2_next[s] = r2_reg[s-1] - trial;
                q2_next[s][NDiv - s] = 1'b1;
            end
        end
    end

    // signed weights, remaining weight, inside test and zeroing for a degenerate triangle
    always_comb
    begin
        w1       = finish(q1_reg[NDiv], s1_reg[NDiv], n1_reg[NDiv]);
        w2       = finish(q2_reg[NDiv], s2_reg[NDiv], n2_reg[NDiv]);
        one_wide = 34'sd1 <<< FRAC_BITS;
        w0_wide  = one_wide - {{2{w1[31]}}, w1} - {{2{w2[31]}}, w2};
        if (w0_wide > 34'sh0_7fff_ffff)
        begin
            w0 = 32'sh7fff_ffff;
        end
        else if (w0_wide < -34'sh0_8000_0000)
        begin
            w0 = 32'sh8000_0000;
        end
        else
        begin
            w0 = w0_wide[31:0];
        end
        ins = !w1[31] && !w2[31] && !w0[31]
            && ({{2{w1[31]}}, w1} <= one_wide)
            && ({{2{w2[31]}}, w2} <= one_wide)
            && ({{2{w0[31]}}, w0} <= one_wide);
        if (dg_reg[NDiv])
        begin
            w1  = '0;
            w2  = '0;
            w0  = '0;
            ins = 1'b0;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NStg; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < NStg; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            r1_reg[0] <= r1_next[0];
            r2_reg[0] <= r2_next[0];
            q1_reg[0] <= q1_next[0];
            q2_reg[0] <= q2_next[0];
            dv_reg[0] <= dv_next;
            s1_reg[0] <= s1_next;
            s2_reg[0] <= s2_next;
            n1_reg[0] <= in_geom.num1[tpb_pkg::NumW-1];
            n2_reg[0] <= in_geom.num2[tpb_pkg::NumW-1];
            dg_reg[0] <= in_geom.degen;
        end
        for (int s = 1; s <= NDiv; s++)
        begin
            if (rdy[s])
            begin
                r1_reg[s] <= r1_next[s];
                r2_reg[s] <= r2_next[s];
                q1_reg[s] <= q1_next[s];
                q2_reg[s] <= q2_next[s];
                dv_reg[s] <= dv_reg[s-1];
                s1_reg[s] <= s1_reg[s-1];
                s2_reg[s] <= s2_reg[s-1];
                n1_reg[s] <= n1_reg[s-1];
                n2_reg[s] <= n2_reg[s-1];
                dg_reg[s] <= dg_reg[s-1];
            end
        end
        if (rdy[NStg-1])
        begin
            w1_reg     <= w1;
            w2_reg     <= w2;
            w0_reg     <= w0;
            ins_reg    <= ins;
            dg_out_reg <= dg_reg[NDiv];
        end
    end

    assign weight_node1 = w1_reg;
    assign weight_node2 = w2_reg;
    assign weight_node0 = w0_reg;
    assign inside_res   = ins_reg;
    assign degenerate   = dg_out_reg;

endmodule

// ===== rtl/triangle_point_barycentric.sv =====
// top level of the triangle point barycentric block
// depends on tpb_pkg, tpb_front, tpb_queue, tpb_back and the macro header

// Takes one triangle and query point per beat and returns one result per beat,
// one item per clock when the output side keeps taking results. Each item
// passes through six front stages that form the exact dot products and Cramer
// terms, a four-entry queue that decouples front from back and registers each
// entry, and a back end that runs a 32-stage pipelined restoring divider (one
// quotient bit per stage, both weights in parallel) between a prep and an
// output stage.
// Weights are Q16.16 by default, rounded to nearest with ties away from zero
// and saturated to 32 bits; a degenerate triangle gives zero weights.
`include "triangle_point_barycentric_macros.svh"

module triangle_point_barycentric #(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] node0_x,
    input  logic signed [31:0] node0_y,
    input  logic signed [31:0] node0_z,
    input  logic signed [31:0] node1_x,
    input  logic signed [31:0] node1_y,
    input  logic signed [31:0] node1_z,
    input  logic signed [31:0] node2_x,
    input  logic signed [31:0] node2_y,
    input  logic signed [31:0] node2_z,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] weight_node1,
    output logic signed [31:0] weight_node2,
    output logic signed [31:0] weight_node0,
    output logic               inside_res,
    output logic               degenerate
);

    tpb_pkg::vec3_t n0, n1, n2, pq;
    tpb_pkg::geom_t front_geom, back_geom;
    logic           front_valid, front_ready, back_valid, back_ready;

    // pack coordinates into vectors
    assign n0 = '{x: node0_x, y: node0_y, z: node0_z};
    assign n1 = '{x: node1_x, y: node1_y, z: node1_z};
    assign n2 = '{x: node2_x, y: node2_y, z: node2_z};
    assign pq = '{x: query_x, y: query_y, z: query_z};

    tpb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .node0     (n0),
        .node1     (n1),
        .node2     (n2),
        .query     (pq),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_geom  (front_geom)
    );

    tpb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_geom   (front_geom),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_geom  (back_geom)
    );

    tpb_back #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (back_valid),
        .in_ready     (back_ready),
        .in_geom      (back_geom),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .weight_node1 (weight_node1),
        .weight_node2 (weight_node2),
        .weight_node0 (weight_node0),
        .inside_res   (inside_res),
        .degenerate   (degenerate)
    );

    `TPB_ASSERT_IMP(a_degen_zero, out_valid && degenerate, weight_node1 == '0 && weight_node2 == '0 && weight_node0 == '0 && !inside_res)
    `TPB_ASSERT_IMP(a_inside_sign, out_valid && inside_res, !weight_node1[31] && !weight_node2[31] && !weight_node0[31] && !degenerate)

endmodule
